### design/tekd_pkg.sv
// ----------------------------------------------------------------------------
// tekd_pkg
// shared types and codes for the terminal escape key decoder
// ----------------------------------------------------------------------------
package tekd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KeyW  = 5;
  localparam int unsigned KindW = 2;

  // parse phase, one-hot
  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_ESC    = 6'b000010,
    PH_SECOND = 6'b000100,
    PH_DIGIT  = 6'b001000,
    PH_MOD    = 6'b010000,
    PH_FINAL  = 6'b100000
  } phase_e;

  typedef enum logic [KindW-1:0] {
    KIND_BYTE = 2'd0,
    KIND_KEY  = 2'd1,
    KIND_FAIL = 2'd2
  } kind_e;

  localparam logic [KeyW-1:0] K_ESC        = 5'd0;
  localparam logic [KeyW-1:0] K_ALT_DIGIT0 = 5'd1;
  localparam logic [KeyW-1:0] K_ALT_PERIOD = 5'd11;
  localparam logic [KeyW-1:0] K_DELETE     = 5'd12;
  localparam logic [KeyW-1:0] K_PAGE_UP    = 5'd13;
  localparam logic [KeyW-1:0] K_PAGE_DOWN  = 5'd14;
  localparam logic [KeyW-1:0] K_CTRL_UP    = 5'd15;
  localparam logic [KeyW-1:0] K_CTRL_DOWN  = 5'd16;
  localparam logic [KeyW-1:0] K_CS_UP      = 5'd17;
  localparam logic [KeyW-1:0] K_CS_DOWN    = 5'd18;
  localparam logic [KeyW-1:0] K_CS_RIGHT   = 5'd19;
  localparam logic [KeyW-1:0] K_CS_LEFT    = 5'd20;
  localparam logic [KeyW-1:0] K_ALT_RIGHT  = 5'd21;
  localparam logic [KeyW-1:0] K_ALT_LEFT   = 5'd22;
  localparam logic [KeyW-1:0] K_UP         = 5'd23;
  localparam logic [KeyW-1:0] K_DOWN       = 5'd24;
  localparam logic [KeyW-1:0] K_RIGHT      = 5'd25;
  localparam logic [KeyW-1:0] K_LEFT       = 5'd26;

  localparam logic [ByteW-1:0] CH_ESC    = 8'h1B;
  localparam logic [ByteW-1:0] CH_LBRACK = 8'h5B;
  localparam logic [ByteW-1:0] CH_TILDE  = 8'h7E;
  localparam logic [ByteW-1:0] CH_SEMI   = 8'h3B;
  localparam logic [ByteW-1:0] CH_PERIOD = 8'h2E;
  localparam logic [ByteW-1:0] CH_ZERO   = 8'h30;
  localparam logic [ByteW-1:0] CH_NINE   = 8'h39;
  localparam logic [ByteW-1:0] CH_THREE  = 8'h33;
  localparam logic [ByteW-1:0] CH_FIVE   = 8'h35;
  localparam logic [ByteW-1:0] CH_SIX    = 8'h36;
  localparam logic [ByteW-1:0] CH_A      = 8'h41;
  localparam logic [ByteW-1:0] CH_B      = 8'h42;
  localparam logic [ByteW-1:0] CH_C      = 8'h43;
  localparam logic [ByteW-1:0] CH_D      = 8'h44;

  typedef struct packed {
    phase_e           phase;
    logic             bracket;
    logic [ByteW-1:0] digit;
    logic [ByteW-1:0] modifier;
  } parse_state_t;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] byte_value;
    logic [KeyW-1:0]  key_code;
  } result_t;

endpackage

### design/tekd_step.sv
// ----------------------------------------------------------------------------
// tekd_step
// one parse step: next state and optional result for one request
// ----------------------------------------------------------------------------
module tekd_step (
  input  tekd_pkg::parse_state_t       state_i,
  input  logic [tekd_pkg::ByteW-1:0]   in_byte_i,
  input  logic                         no_byte_i,
  output tekd_pkg::parse_state_t       state_o,
  output logic                         res_valid_o,
  output tekd_pkg::result_t            res_o
);

  function automatic logic [tekd_pkg::KeyW-1:0] decode_mod(
    input logic [tekd_pkg::ByteW-1:0] m,
    input logic [tekd_pkg::ByteW-1:0] f
  );
    logic [tekd_pkg::KeyW-1:0] k;
    k = tekd_pkg::K_ESC;
    if (m == tekd_pkg::CH_FIVE) begin
      if (f == tekd_pkg::CH_A) k = tekd_pkg::K_CTRL_UP;
      else if (f == tekd_pkg::CH_B) k = tekd_pkg::K_CTRL_DOWN;
    end else if (m == tekd_pkg::CH_SIX) begin
      if (f == tekd_pkg::CH_A) k = tekd_pkg::K_CS_UP;
      else if (f == tekd_pkg::CH_B) k = tekd_pkg::K_CS_DOWN;
      else if (f == tekd_pkg::CH_C) k = tekd_pkg::K_CS_RIGHT;
      else if (f == tekd_pkg::CH_D) k = tekd_pkg::K_CS_LEFT;
    end else if (m == tekd_pkg::CH_THREE) begin
      if (f == tekd_pkg::CH_C) k = tekd_pkg::K_ALT_RIGHT;
      else if (f == tekd_pkg::CH_D) k = tekd_pkg::K_ALT_LEFT;
    end
    return k;
  endfunction

  logic                      is_digit;
  logic [tekd_pkg::KeyW-1:0] key;
  logic                      key_hit;

  assign is_digit = (in_byte_i >= tekd_pkg::CH_ZERO) && (in_byte_i <= tekd_pkg::CH_NINE);

  always_comb begin
    state_o          = state_i;
    res_valid_o      = 1'b0;
    res_o.kind       = tekd_pkg::KIND_BYTE;
    res_o.byte_value = '0;
    res_o.key_code   = '0;
    key              = tekd_pkg::K_ESC;
    key_hit          = 1'b0;

    unique case (state_i.phase)
      tekd_pkg::PH_ESC: begin
        if (no_byte_i) begin
          key_hit = 1'b1;
        end else if (is_digit) begin
          key_hit = 1'b1;
          key     = tekd_pkg::K_ALT_DIGIT0 + tekd_pkg::KeyW'(in_byte_i - tekd_pkg::CH_ZERO);
        end else if (in_byte_i == tekd_pkg::CH_PERIOD) begin
          key_hit = 1'b1;
          key     = tekd_pkg::K_ALT_PERIOD;
        end else begin
          state_o.bracket = (in_byte_i == tekd_pkg::CH_LBRACK);
          state_o.phase   = tekd_pkg::PH_SECOND;
        end
      end
      tekd_pkg::PH_SECOND: begin
        if (no_byte_i || !state_i.bracket) begin
          key_hit = 1'b1;
        end else if (is_digit) begin
          state_o.digit = in_byte_i;
          state_o.phase = tekd_pkg::PH_DIGIT;
        end else begin
          key_hit = 1'b1;
          unique case (in_byte_i)
            tekd_pkg::CH_A: key = tekd_pkg::K_UP;
            tekd_pkg::CH_B: key = tekd_pkg::K_DOWN;
            tekd_pkg::CH_C: key = tekd_pkg::K_RIGHT;
            tekd_pkg::CH_D: key = tekd_pkg::K_LEFT;
            default:        key = tekd_pkg::K_ESC;
          endcase
        end
      end
      tekd_pkg::PH_DIGIT: begin
        if (!no_byte_i && in_byte_i == tekd_pkg::CH_SEMI) begin
          state_o.phase = tekd_pkg::PH_MOD;
        end else begin
          key_hit = 1'b1;
          if (!no_byte_i && in_byte_i == tekd_pkg::CH_TILDE) begin
            unique case (state_i.digit)
              tekd_pkg::CH_THREE: key = tekd_pkg::K_DELETE;
              tekd_pkg::CH_FIVE:  key = tekd_pkg::K_PAGE_UP;
              tekd_pkg::CH_SIX:   key = tekd_pkg::K_PAGE_DOWN;
              default:            key = tekd_pkg::K_ESC;
            endcase
          end
        end
      end
      tekd_pkg::PH_MOD: begin
        if (no_byte_i) begin
          key_hit = 1'b1;
        end else begin
          state_o.modifier = in_byte_i;
          state_o.phase    = tekd_pkg::PH_FINAL;
        end
      end
      tekd_pkg::PH_FINAL: begin
        key_hit = 1'b1;
        if (!no_byte_i) key = decode_mod(state_i.modifier, in_byte_i);
      end
      default: begin
        // idle, and any code that cannot arise
        state_o.phase = tekd_pkg::PH_IDLE;
        if (no_byte_i) begin
          res_valid_o = 1'b1;
          res_o.kind  = tekd_pkg::KIND_FAIL;
        end else if (in_byte_i == tekd_pkg::CH_ESC) begin
          state_o.phase = tekd_pkg::PH_ESC;
        end else begin
          res_valid_o      = 1'b1;
          res_o.byte_value = in_byte_i;
        end
      end
    endcase

    if (key_hit) begin
      state_o.phase  = tekd_pkg::PH_IDLE;
      res_valid_o    = 1'b1;
      res_o.kind     = tekd_pkg::KIND_KEY;
      res_o.key_code = key;
    end
  end

endmodule

### design/terminal_escape_key_decoder.sv
// ----------------------------------------------------------------------------
// terminal_escape_key_decoder
// decodes a terminal byte stream into plain bytes and escape-sequence keys
// ----------------------------------------------------------------------------
// an accepted request's result is registered and shows on the output in the next cycle
// throughput: one request per cycle while the result side is ready, set by the single result register
// a request that ends no result (ESC or a partial sequence) only moves state
// reset: asynchronous active-low, parser returns to idle, output empties
// ----------------------------------------------------------------------------
module terminal_escape_key_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic [0:0]  s_axis_tuser,   // [0] no_byte
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] byte_value, [12:8] key_code, rest zero
  output logic [1:0]  m_axis_tuser    // [1:0] result_kind
);

  // parser state and step logic
  tekd_pkg::parse_state_t state_q, state_d;
  logic                   res_valid;
  tekd_pkg::result_t      res;

  // output register
  logic              out_valid_q, out_valid_d;
  tekd_pkg::result_t out_q, out_d;

  logic in_acc;

  // ready whenever the result register is free or draining this cycle
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  tekd_step u_step (
    .state_i     (state_q),
    .in_byte_i   (s_axis_tdata),
    .no_byte_i   (s_axis_tuser[0]),
    .state_o     (state_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (m_axis_tready) out_valid_d = 1'b0;
    if (in_acc && res_valid) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase    <= tekd_pkg::PH_IDLE;
      state_q.bracket  <= 1'b0;
      state_q.digit    <= '0;
      state_q.modifier <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      if (in_acc) state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.key_code, out_q.byte_value};
  assign m_axis_tuser  = out_q.kind;

  // a failure or key result never carries a byte, a byte result never a key
  a_fields_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ((m_axis_tuser == tekd_pkg::KIND_BYTE) && (m_axis_tdata[12:8] == '0)) ||
      ((m_axis_tuser == tekd_pkg::KIND_KEY)  && (m_axis_tdata[7:0] == '0)) ||
      ((m_axis_tuser == tekd_pkg::KIND_FAIL) && (m_axis_tdata == '0)))
    else $error("result fields not clean for kind");

  // an ESC taken while idle opens a sequence and gives no result
  a_esc_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && state_q.phase == tekd_pkg::PH_IDLE && !s_axis_tuser[0] &&
     s_axis_tdata == tekd_pkg::CH_ESC)
    |=> (state_q.phase == tekd_pkg::PH_ESC) && !(m_axis_tvalid && !$past(out_valid_q)))
    else $error("esc did not open a sequence");

  // a missing byte, inside a sequence or while idle, returns the parser to idle with a result
  a_timeout_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser[0]) |=> (state_q.phase == tekd_pkg::PH_IDLE) && m_axis_tvalid)
    else $error("missing byte did not end the sequence");

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// stream-level check of terminal_escape_key_decoder: a short table of
// directed requests, then random escape sequences, plain bytes and broken
// sequences under changing idle and stall patterns; every result is compared
// against a hand-typed value or an in-bench decoder that tracks the parse state
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HalfPeriod = 4;
  localparam int unsigned ResetCycles = 8;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned ItemsPerPhase = 355;
  localparam int unsigned MaxReports = 10;

  // one request as offered, with an optional hand-typed result
  typedef struct packed {
    logic [tekd_pkg::ByteW-1:0] data;
    logic                       none;
    logic                       typed;
    tekd_pkg::result_t          want;
  } request_t;

  localparam tekd_pkg::result_t NoResult = '{tekd_pkg::KIND_BYTE, 8'h00, tekd_pkg::K_ESC};

  // directed table: typed results only where they follow at a glance
  localparam int unsigned NumDirected = 28;
  localparam request_t Directed [NumDirected] = '{
    // nothing arrives while idle
    '{8'h00, 1'b1, 1'b1, '{tekd_pkg::KIND_FAIL, 8'h00, tekd_pkg::K_ESC}},
    // plain byte extremes, high bytes stay unsigned
    '{8'h00, 1'b0, 1'b1, '{tekd_pkg::KIND_BYTE, 8'h00, tekd_pkg::K_ESC}},
    '{8'hFF, 1'b0, 1'b1, '{tekd_pkg::KIND_BYTE, 8'hFF, tekd_pkg::K_ESC}},
    '{8'h80, 1'b0, 1'b1, '{tekd_pkg::KIND_BYTE, 8'h80, tekd_pkg::K_ESC}},
    // alt plus lowest and highest digit, alt plus period
    '{tekd_pkg::CH_ESC, 1'b0, 1'b0, NoResult},
    '{tekd_pkg::CH_ZERO, 1'b0, 1'b1,
      '{tekd_pkg::KIND_KEY, 8'h00, tekd_pkg::K_ALT_DIGIT0}},
    '{tekd_pkg::CH_ESC, 1'b0, 1'b0, NoResult},
    '{tekd_pkg::CH_NINE, 1'b0, 1'b1,
      '{tekd_pkg::KIND_KEY, 8'h00, tekd_pkg::K_ALT_DIGIT0 + 5'd9}},
    '{tekd_pkg::CH_ESC, 1'b0, 1'b0, NoResult},
    '{tekd_pkg::CH_PERIOD, 1'b0, 1'b1,
      '{tekd_pkg::KIND_KEY, 8'h00, tekd_pkg::K_ALT_PERIOD}},
    // plain arrow
    '{tekd_pkg::CH_ESC, 1'b0, 1'b0, NoResult},
    '{tekd_pkg::CH_LBRACK, 1'b0, 1'b0, NoResult},
    '{tekd_pkg::CH_A, 1'b0, 1'b1, '{tekd_pkg::KIND_KEY, 8'h00, tekd_pkg::K_UP}},
    // delete
    '{tekd_pkg::CH_ESC, 1'b0, 1'b0, NoResult},
    '{tekd_pkg::CH_LBRACK, 1'b0, 1'b0, NoResult},
    '{tekd_pkg::CH_THREE, 1'b0, 1'b0, NoResult},
    '{tekd_pkg::CH_TILDE, 1'b0, 1'b1,
      '{tekd_pkg::KIND_KEY, 8'h00, tekd_pkg::K_DELETE}},
    // modified arrow, the leading digit is not checked
    '{tekd_pkg::CH_ESC, 1'b0, 1'b0, NoResult},
    '{tekd_pkg::CH_LBRACK, 1'b0, 1'b0, NoResult},
    '{8'h31, 1'b0, 1'b0, NoResult},
    '{tekd_pkg::CH_SEMI, 1'b0, 1'b0, NoResult},
    '{tekd_pkg::CH_SIX, 1'b0, 1'b0, NoResult},
    '{tekd_pkg::CH_D, 1'b0, 1'b1,
      '{tekd_pkg::KIND_KEY, 8'h00, tekd_pkg::K_CS_LEFT}},
    // second byte not a bracket: third byte is swallowed into ESC
    '{tekd_pkg::CH_ESC, 1'b0, 1'b0, NoResult},
    '{8'h78, 1'b0, 1'b0, NoResult},
    '{8'h71, 1'b0, 1'b1, '{tekd_pkg::KIND_KEY, 8'h00, tekd_pkg::K_ESC}},
    // sequence cut short by a missing byte
    '{tekd_pkg::CH_ESC, 1'b0, 1'b0, NoResult},
    '{8'hFF, 1'b1, 1'b1, '{tekd_pkg::KIND_KEY, 8'h00, tekd_pkg::K_ESC}}
  };

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata = '0;
  logic [0:0]       s_axis_tuser = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [15:0]      m_axis_tdata;
  logic [1:0]       m_axis_tuser;

  // decoder state as the bench sees it
  tekd_pkg::phase_e           dec_phase = tekd_pkg::PH_IDLE;
  logic                       dec_bracket = 1'b0;
  logic [tekd_pkg::ByteW-1:0] dec_digit = '0;
  logic [tekd_pkg::ByteW-1:0] dec_modifier = '0;

  request_t          offered_requests [$];
  tekd_pkg::result_t pending_results [$];
  int unsigned       errors = 0;
  int unsigned       items_sent = 0;
  int unsigned       idle_pct = 0;
  int unsigned       stall_pct = 0;
  int unsigned       hold_left = 0;
  int unsigned       quiet_cycles = 0;

  terminal_escape_key_decoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #(HalfPeriod * 1ns) clk_i = ~clk_i;

  function automatic logic is_digit(input logic [tekd_pkg::ByteW-1:0] b);
    return b >= tekd_pkg::CH_ZERO && b <= tekd_pkg::CH_NINE;
  endfunction

  // advance the parse state by one request; returns 1 when a result is due
  function automatic logic decode_byte(input logic [tekd_pkg::ByteW-1:0] b,
                                       input logic none,
                                       output tekd_pkg::result_t r);
    logic done;
    r = NoResult;
    done = 1'b1;
    if (dec_phase == tekd_pkg::PH_IDLE) begin
      if (none) begin
        r.kind = tekd_pkg::KIND_FAIL;
      end else if (b == tekd_pkg::CH_ESC) begin
        dec_phase = tekd_pkg::PH_ESC;
        done = 1'b0;
      end else begin
        r.byte_value = b;
      end
      return done;
    end
    r.kind = tekd_pkg::KIND_KEY;
    if (!none) begin
      case (dec_phase)
        tekd_pkg::PH_ESC: begin
          if (is_digit(b)) begin
            r.key_code = tekd_pkg::K_ALT_DIGIT0 + 5'(b - tekd_pkg::CH_ZERO);
          end else if (b == tekd_pkg::CH_PERIOD) begin
            r.key_code = tekd_pkg::K_ALT_PERIOD;
          end else begin
            dec_bracket = (b == tekd_pkg::CH_LBRACK);
            dec_phase = tekd_pkg::PH_SECOND;
            done = 1'b0;
          end
        end
        tekd_pkg::PH_SECOND: begin
          if (dec_bracket && is_digit(b)) begin
            dec_digit = b;
            dec_phase = tekd_pkg::PH_DIGIT;
            done = 1'b0;
          end else if (dec_bracket) begin
            case (b)
              tekd_pkg::CH_A: r.key_code = tekd_pkg::K_UP;
              tekd_pkg::CH_B: r.key_code = tekd_pkg::K_DOWN;
              tekd_pkg::CH_C: r.key_code = tekd_pkg::K_RIGHT;
              tekd_pkg::CH_D: r.key_code = tekd_pkg::K_LEFT;
              default: r.key_code = tekd_pkg::K_ESC;
            endcase
          end
        end
        tekd_pkg::PH_DIGIT: begin
          if (b == tekd_pkg::CH_TILDE) begin
            case (dec_digit)
              tekd_pkg::CH_THREE: r.key_code = tekd_pkg::K_DELETE;
              tekd_pkg::CH_FIVE: r.key_code = tekd_pkg::K_PAGE_UP;
              tekd_pkg::CH_SIX: r.key_code = tekd_pkg::K_PAGE_DOWN;
              default: r.key_code = tekd_pkg::K_ESC;
            endcase
          end else if (b == tekd_pkg::CH_SEMI) begin
            dec_phase = tekd_pkg::PH_MOD;
            done = 1'b0;
          end
        end
        tekd_pkg::PH_MOD: begin
          dec_modifier = b;
          dec_phase = tekd_pkg::PH_FINAL;
          done = 1'b0;
        end
        default: begin
          // final byte of a modified arrow
          if (dec_modifier == tekd_pkg::CH_FIVE) begin
            if (b == tekd_pkg::CH_A) r.key_code = tekd_pkg::K_CTRL_UP;
            else if (b == tekd_pkg::CH_B) r.key_code = tekd_pkg::K_CTRL_DOWN;
          end else if (dec_modifier == tekd_pkg::CH_SIX) begin
            if (b == tekd_pkg::CH_A) r.key_code = tekd_pkg::K_CS_UP;
            else if (b == tekd_pkg::CH_B) r.key_code = tekd_pkg::K_CS_DOWN;
            else if (b == tekd_pkg::CH_C) r.key_code = tekd_pkg::K_CS_RIGHT;
            else if (b == tekd_pkg::CH_D) r.key_code = tekd_pkg::K_CS_LEFT;
          end else if (dec_modifier == tekd_pkg::CH_THREE) begin
            if (b == tekd_pkg::CH_C) r.key_code = tekd_pkg::K_ALT_RIGHT;
            else if (b == tekd_pkg::CH_D) r.key_code = tekd_pkg::K_ALT_LEFT;
          end
        end
      endcase
    end
    if (done) dec_phase = tekd_pkg::PH_IDLE;
    return done;
  endfunction

  // results are checked before the same edge's request updates the state
  always @(posedge clk_i) begin : monitor
    tekd_pkg::result_t want;
    tekd_pkg::result_t got;
    request_t          req;
    logic              has_result;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= MaxReports)
            $display("unexpected result: kind %0d tdata %04h", m_axis_tuser, m_axis_tdata);
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tuser !== want.kind ||
              m_axis_tdata !== {3'b000, want.key_code, want.byte_value}) begin
            errors++;
            if (errors <= MaxReports)
              $display("mismatch: got kind %0d byte %02h key %0d tdata[15:13] %0d,",
                       m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[12:8],
                       m_axis_tdata[15:13],
                       " expected kind %0d byte %02h key %0d",
                       want.kind, want.byte_value, want.key_code);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        req = offered_requests.pop_front();
        has_result = decode_byte(s_axis_tdata, s_axis_tuser[0], got);
        if (req.typed) pending_results.push_back(req.want);
        else if (has_result) pending_results.push_back(got);
      end
      // watchdog: a run with no traffic on either side is hung
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("** terminal_escape_key_decoder: FAILED **");
        $finish;
      end
    end
  end

  // result side: random stalls, plus a long hold-off counted here
  always begin
    @(posedge clk_i);
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // offer one request and wait until it is taken
  task automatic offer(input logic [tekd_pkg::ByteW-1:0] data, input logic none,
                       input logic typed = 1'b0,
                       input tekd_pkg::result_t want = NoResult);
    offered_requests.push_back('{data, none, typed, want});
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= data;
    s_axis_tuser <= none;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // stop offering until every result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0 || offered_requests.size() != 0);
  endtask

  // a byte that tends to steer the parser somewhere interesting
  function automatic logic [tekd_pkg::ByteW-1:0] seq_byte();
    case ($urandom_range(7))
      0: return tekd_pkg::CH_LBRACK;
      1: return tekd_pkg::CH_ZERO + 8'($urandom_range(9));
      2: return tekd_pkg::CH_SEMI;
      3: return tekd_pkg::CH_TILDE;
      4: return tekd_pkg::CH_A + 8'($urandom_range(3));
      5: return tekd_pkg::CH_PERIOD;
      6: return tekd_pkg::CH_ESC;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // mostly the digits that mean something after '[' or ';'
  function automatic logic [tekd_pkg::ByteW-1:0] key_digit();
    case ($urandom_range(3))
      0: return tekd_pkg::CH_THREE;
      1: return tekd_pkg::CH_FIVE;
      2: return tekd_pkg::CH_SIX;
      default: return tekd_pkg::CH_ZERO + 8'($urandom_range(9));
    endcase
  endfunction

  task automatic send_random_unit();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(99);
    if (pick < 18) begin
      offer(8'($urandom_range(255)), 1'b0);
    end else if (pick < 23) begin
      offer(8'($urandom_range(255)), 1'b1);
    end else if (pick < 82) begin
      // mostly well-formed sequence with random content
      offer(tekd_pkg::CH_ESC, 1'b0);
      case ($urandom_range(4))
        0: offer(tekd_pkg::CH_ZERO + 8'($urandom_range(9)), 1'b0);
        1: offer(tekd_pkg::CH_PERIOD, 1'b0);
        2: begin
          offer(tekd_pkg::CH_LBRACK, 1'b0);
          offer(tekd_pkg::CH_A + 8'($urandom_range(3)), 1'b0);
        end
        3: begin
          offer(tekd_pkg::CH_LBRACK, 1'b0);
          offer(key_digit(), 1'b0);
          offer(tekd_pkg::CH_TILDE, 1'b0);
        end
        default: begin
          offer(tekd_pkg::CH_LBRACK, 1'b0);
          offer(tekd_pkg::CH_ZERO + 8'($urandom_range(9)), 1'b0);
          offer(tekd_pkg::CH_SEMI, 1'b0);
          offer(($urandom_range(4) != 0) ? key_digit() : 8'($urandom_range(255)), 1'b0);
          offer(($urandom_range(3) != 0) ? tekd_pkg::CH_A + 8'($urandom_range(3))
                                         : seq_byte(),
                1'b0);
        end
      endcase
    end else begin
      // broken or unknown sequence, sometimes cut short
      offer(tekd_pkg::CH_ESC, 1'b0);
      len = $urandom_range(4, 1);
      repeat (len) offer(seq_byte(), ($urandom_range(9) == 0));
    end
  endtask

  initial begin
    int unsigned idle_plan [4] = '{0, 75, 0, 16};
    int unsigned stall_plan [4] = '{0, 0, 75, 16};
    int unsigned target;
    logic        held;
    held = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (Directed[i])
      offer(Directed[i].data, Directed[i].none, Directed[i].typed, Directed[i].want);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_plan[ph];
      stall_pct = stall_plan[ph];
      target = items_sent + ItemsPerPhase;
      while (items_sent < target) begin
        // long output hold-off while requests keep coming, so input backs up
        if (ph == 0 && !held && items_sent + 200 > target) begin
          hold_left = 80;
          held = 1'b1;
        end
        send_random_unit();
      end
      drain();
    end

    repeat (4) @(posedge clk_i);
    if (errors == 0) begin
      $display("** terminal_escape_key_decoder: PASSED **");
    end else begin
      $display("** terminal_escape_key_decoder: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
design/tekd_pkg.sv
design/tekd_step.sv
design/terminal_escape_key_decoder.sv
sim/tb.sv
